>>> hw/rtl/ssbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_pkg
// Shared types and constants of the sample slicer and bit packer.
// ----------------------------------------------------------------------------
package ssbp_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [7:0] CFG_SLICE_MODE       = 8'd0;
  localparam logic [7:0] CFG_SIMPLE_THRESHOLD = 8'd1;
  localparam logic [7:0] CFG_RISE_POINT       = 8'd2;
  localparam logic [7:0] CFG_FALL_POINT       = 8'd3;

  localparam logic       MODE_RESET   = 1'b0;
  localparam logic [7:0] THRESH_RESET = 8'd127;
  localparam logic [7:0] RISE_RESET   = 8'hc3;
  localparam logic [7:0] FALL_RESET   = 8'h3c;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_BUCKET = 1'b1;

  localparam logic MODE_SIMPLE  = 1'b0;
  localparam logic MODE_SCHMITT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] sample;
    logic       end_of_input;
    logic [4:0] bucket_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  packed_byte;
    logic [3:0]  bits_in_byte;
    logic        final_byte;
    logic [31:0] bucket_count;
  } out_item_t;

  typedef struct packed {
    logic       slice_mode;
    logic [7:0] simple_threshold;
    logic [7:0] rise_point;
    logic [7:0] fall_point;
  } slice_cfg_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] packed_byte;
    logic [3:0] bits_in_byte;
    logic       final_byte;
  } pack_res_t;

endpackage

>>> hw/rtl/sample_slicer_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_slicer_bit_packer
// One-bit audio slicer with MSB-first bit packer and amplitude histogram.
// ----------------------------------------------------------------------------
// Accepts one word per cycle while the output buffer has room. A word is
// registered on accept, and in the next cycle the slicer, the packer and the
// histogram read-modify-write finish it; a result is then written into a
// two-entry output buffer, which drives out_valid. The histogram RAM read is
// launched at accept and a write-to-read bypass keeps back-to-back samples in
// the same bucket exact.
// Histogram counters start cleared after reset through per-bucket valid bits,
// with no clearing pass. Configuration writes are always taken (cfg_ready is
// high) and must only happen while no word is in flight.
// ----------------------------------------------------------------------------
module sample_slicer_bit_packer #(
  parameter int unsigned BUCKET_COUNT = 32,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssbp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssbp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  import ssbp_pkg::*;

  localparam int unsigned AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  slice_cfg_t cfg;
  logic       s1_valid;
  in_item_t   s1_item;
  logic       accept;
  logic [1:0] level;
  logic       pop;

  logic [16:0]      prod;
  logic [8:0]       bsel;
  logic [AW-1:0]    rd_addr;
  logic             rd_oor;
  logic             feed;
  logic [COUNT_WIDTH-1:0] count;
  logic [63:0]      count_ext;
  pack_res_t        pres;
  logic             push;
  out_item_t        push_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice_mode       <= MODE_RESET;
      cfg.simple_threshold <= THRESH_RESET;
      cfg.rise_point       <= RISE_RESET;
      cfg.fall_point       <= FALL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLICE_MODE:       cfg.slice_mode       <= cfg_data[0];
        CFG_SIMPLE_THRESHOLD: cfg.simple_threshold <= cfg_data;
        CFG_RISE_POINT:       cfg.rise_point       <= cfg_data;
        CFG_FALL_POINT:       cfg.fall_point       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // space check counts the word in flight and a pop at this edge
  assign pop      = out_valid && out_ready;
  assign in_ready = ({1'b0, level} + 3'(s1_valid)) <= (3'd1 + 3'(pop));
  assign accept   = in_valid && in_ready;

  always_comb begin
    prod = 17'(in_data.sample) * 17'(BUCKET_COUNT);
    bsel = prod[16:8];
    if (bsel >= 9'(BUCKET_COUNT)) begin
      bsel = 9'(BUCKET_COUNT - 1);
    end
    rd_oor = 1'b0;
    if (in_data.cmd == CMD_READ) begin
      rd_addr = AW'(in_data.bucket_index);
      rd_oor  = (9'(in_data.bucket_index) >= 9'(BUCKET_COUNT));
    end else begin
      rd_addr = AW'(bsel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  assign feed = s1_valid && (s1_item.cmd == CMD_FEED);

  ssbp_hist #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_oor  (rd_oor),
    .upd     (feed),
    .count   (count)
  );

  ssbp_packer u_packer (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .sample (s1_item.sample),
    .last   (s1_item.end_of_input),
    .cfg    (cfg),
    .res    (pres)
  );

  always_comb begin
    count_ext = 64'(count);
    push_data = '0;
    if (s1_item.cmd == CMD_READ) begin
      push              = s1_valid;
      push_data.result_kind  = KIND_BUCKET;
      push_data.bucket_count = count_ext[31:0];
    end else begin
      push              = s1_valid && pres.emit;
      push_data.result_kind  = KIND_DATA;
      push_data.packed_byte  = pres.packed_byte;
      push_data.bits_in_byte = pres.bits_in_byte;
      push_data.final_byte   = pres.final_byte;
    end
  end

  ssbp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (level)
  );

endmodule

>>> hw/rtl/ssbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ssbp_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_hist
// Amplitude histogram: saturating counters in RAM with per-entry valid bits,
// read launched on accept, read-modify-write in the following cycle with bypass.
// ----------------------------------------------------------------------------
module ssbp_hist #(
  parameter int unsigned BUCKET_COUNT = 32,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             rd_en,
  input  logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] rd_addr,
  input  logic                                             rd_oor,
  input  logic                                             upd,
  output logic [COUNT_WIDTH-1:0]                           count
);

  localparam int unsigned AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic [BUCKET_COUNT-1:0] vld;
  logic [AW-1:0]           addr_q;
  logic                    vld_q;
  logic                    oor_q;
  logic                    byp_hit;
  logic [COUNT_WIDTH-1:0]  byp_data;
  logic [COUNT_WIDTH-1:0]  ram_q;
  logic [COUNT_WIDTH-1:0]  cur;
  logic [COUNT_WIDTH-1:0]  wdata;

  always_comb begin
    if (oor_q) begin
      cur = '0;
    end else if (byp_hit) begin
      cur = byp_data;
    end else if (vld_q) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    wdata = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + COUNT_WIDTH'(1);
  end

  assign count = cur;

  ssbp_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BUCKET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (upd),
    .waddr (addr_q),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (upd) begin
      vld[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= rd_addr;
      vld_q    <= vld[rd_addr];
      oor_q    <= rd_oor;
      byp_hit  <= upd && (addr_q == rd_addr);
      byp_data <= wdata;
    end
  end

endmodule

>>> hw/rtl/ssbp_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_packer
// Slices a sample to one bit (threshold or Schmitt trigger) and packs bits
// MSB first into bytes.
// ----------------------------------------------------------------------------
module ssbp_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               feed,
  input  logic [7:0]         sample,
  input  logic               last,
  input  ssbp_pkg::slice_cfg_t cfg,
  output ssbp_pkg::pack_res_t  res
);

  import ssbp_pkg::*;

  logic       schmitt_level;
  logic [7:0] bit_shifter;
  logic [2:0] bit_position;

  logic       level_next;
  logic       bit_val;
  logic [3:0] filled;
  logic [7:0] shifter_next;

  always_comb begin
    if (schmitt_level) begin
      level_next = !(sample < cfg.fall_point);
    end else begin
      level_next = (sample >= cfg.rise_point);
    end
    bit_val      = (cfg.slice_mode == MODE_SCHMITT) ? level_next
                                                   : (sample > cfg.simple_threshold);
    filled       = {1'b0, bit_position} + 4'd1;
    shifter_next = bit_shifter | ({bit_val, 7'b0} >> bit_position);
    res.emit         = (filled >= 4'(BITS_PER_BYTE)) || last;
    res.packed_byte  = shifter_next;
    res.bits_in_byte = filled;
    res.final_byte   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      schmitt_level <= 1'b0;
      bit_shifter   <= '0;
      bit_position  <= '0;
    end else if (feed) begin
      if (cfg.slice_mode == MODE_SCHMITT) begin
        schmitt_level <= level_next;
      end
      if (res.emit) begin
        bit_shifter  <= '0;
        bit_position <= '0;
      end else begin
        bit_shifter  <= shifter_next;
        bit_position <= filled[2:0];
      end
    end
  end

endmodule

>>> hw/rtl/ssbp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_out_buf
// Two-entry result buffer driving the output channel.
// ----------------------------------------------------------------------------
module ssbp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ssbp_pkg::out_item_t push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssbp_pkg::out_item_t out_data,
  output logic [1:0]          level
);

  import ssbp_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign out_valid = (level != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      level <= level + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> verif/tb_sample_slicer_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_slicer_bit_packer
// Self-checking bench for the one-bit slicer, bit packer and histogram.
// A queue-fed driver pushes sample and bucket-read words with random gaps
// while the result side stalls at random. Every accepted word runs through
// a local slicer/packer/histogram predictor, and each returned word is
// checked field by field against the oldest prediction. Each phase rewrites
// the slicer registers (simple mode, Schmitt mode, threshold extremes and
// random settings), then sends its words and drains.
// ----------------------------------------------------------------------------
module tb_sample_slicer_bit_packer;
  import ssbp_pkg::*;

  localparam int unsigned NUM_BUCKETS  = 32;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned PIPE_CYCLES  = 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 210;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  in_item_t    sample_backlog[$];
  out_item_t   awaited_results[$];
  slice_cfg_t  slicer_regs;
  logic        schmitt_state;
  logic [7:0]  shift_byte;
  logic [2:0]  bits_held;
  logic [31:0] hist_counts [NUM_BUCKETS];
  logic        quiet = 1'b0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  sample_slicer_bit_packer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #4 clk = ~clk;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  function automatic void slice_and_pack(input in_item_t w, output bit emit,
                                         output out_item_t r);
    logic       slice;
    logic [3:0] filled;
    logic [4:0] bucket;
    r = '0;
    emit = 1'b0;
    if (w.cmd == CMD_READ) begin
      r.result_kind = KIND_BUCKET;
      r.bucket_count = hist_counts[w.bucket_index];
      emit = 1'b1;
      return;
    end
    bucket = w.sample[7:3];
    if (hist_counts[bucket] != '1) hist_counts[bucket] = hist_counts[bucket] + 1;
    if (slicer_regs.slice_mode == MODE_SIMPLE) begin
      slice = w.sample > slicer_regs.simple_threshold;
    end else begin
      if (!schmitt_state) begin
        if (w.sample >= slicer_regs.rise_point) schmitt_state = 1'b1;
      end else if (w.sample < slicer_regs.fall_point) begin
        schmitt_state = 1'b0;
      end
      slice = schmitt_state;
    end
    if (slice) shift_byte[3'd7 - bits_held] = 1'b1;
    filled = {1'b0, bits_held} + 4'd1;
    if (filled == 4'(BITS_PER_BYTE) || w.end_of_input) begin
      r.result_kind = KIND_DATA;
      r.packed_byte = shift_byte;
      r.bits_in_byte = filled;
      r.final_byte = w.end_of_input;
      emit = 1'b1;
      shift_byte = '0;
      bits_held = '0;
    end else begin
      bits_held = filled[2:0];
    end
  endfunction

  // word driver
  always @(posedge clk) begin : drive
    bit        emit;
    out_item_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        slice_and_pack(in_data, emit, r);
        if (emit) awaited_results.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (sample_backlog.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
          in_valid <= 1'b1;
          in_data <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report("word with nothing awaited", out_data.bucket_count, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.result_kind !== want.result_kind)
            report("result_kind", 32'(out_data.result_kind), 32'(want.result_kind));
          if (out_data.packed_byte !== want.packed_byte)
            report("packed_byte", 32'(out_data.packed_byte), 32'(want.packed_byte));
          if (out_data.bits_in_byte !== want.bits_in_byte)
            report("bits_in_byte", 32'(out_data.bits_in_byte),
                   32'(want.bits_in_byte));
          if (out_data.final_byte !== want.final_byte)
            report("final_byte", 32'(out_data.final_byte), 32'(want.final_byte));
          if (out_data.bucket_count !== want.bucket_count)
            report("bucket_count", out_data.bucket_count, want.bucket_count);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SLICE_MODE:       slicer_regs.slice_mode = val[0];
      CFG_SIMPLE_THRESHOLD: slicer_regs.simple_threshold = val;
      CFG_RISE_POINT:       slicer_regs.rise_point = val;
      CFG_FALL_POINT:       slicer_regs.fall_point = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  task automatic feed(logic [7:0] s, logic last);
    in_item_t w;
    w.cmd = CMD_FEED;
    w.sample = s;
    w.end_of_input = last;
    w.bucket_index = 5'($urandom);
    sample_backlog.push_back(w);
  endtask

  task automatic read_bucket(logic [4:0] idx);
    in_item_t w;
    w.cmd = CMD_READ;
    w.sample = 8'($urandom);
    w.end_of_input = 1'($urandom);
    w.bucket_index = idx;
    sample_backlog.push_back(w);
  endtask

  // samples cluster around the threshold or a switching point half the time
  function automatic logic [7:0] pick_sample();
    int center;
    int s;
    if ($urandom_range(1) == 0) return 8'($urandom);
    case ($urandom_range(2))
      0:       center = int'(slicer_regs.simple_threshold);
      1:       center = int'(slicer_regs.rise_point);
      default: center = int'(slicer_regs.fall_point);
    endcase
    s = center + int'($urandom_range(6)) - 3;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  initial begin
    logic       mode;
    logic [7:0] thr;
    logic [7:0] rp;
    logic [7:0] fp;
    slicer_regs = '{MODE_RESET, THRESH_RESET, RISE_RESET, FALL_RESET};
    schmitt_state = 1'b0;
    shift_byte = '0;
    bits_held = '0;
    foreach (hist_counts[i]) hist_counts[i] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // simple slicing at reset threshold, partial and full last bytes
    feed(8'd0, 1'b0);
    feed(8'd255, 1'b0);
    feed(8'd127, 1'b0);
    feed(8'd128, 1'b0);
    feed(8'd200, 1'b1);
    for (int i = 0; i < 8; i++) feed((i % 3 == 0) ? 8'd255 : 8'd0, i == 7);
    read_bucket(5'd0);
    read_bucket(5'd31);
    read_bucket(5'd16);
    drain();

    // schmitt mode at reset rise and fall points
    write_reg(CFG_SLICE_MODE, {7'($urandom), MODE_SCHMITT});
    feed(8'd194, 1'b0);
    feed(8'd195, 1'b0);
    feed(8'd100, 1'b0);
    feed(8'd60, 1'b0);
    feed(8'd59, 1'b0);
    feed(8'd255, 1'b1);
    read_bucket(5'd7);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      mode = 1'($urandom);
      thr = 8'($urandom);
      rp = 8'($urandom);
      fp = 8'($urandom);
      case (p)
        0: begin mode = MODE_SIMPLE;  thr = 8'd0;   end
        1: begin mode = MODE_SIMPLE;  thr = 8'd255; end
        2: begin mode = MODE_SCHMITT; rp = 8'd255;  fp = 8'd0;   end
        3: begin mode = MODE_SCHMITT; rp = 8'd0;    fp = 8'd255; end
        5: begin mode = MODE_SCHMITT; rp = 8'd128 + 8'($urandom_range(100));
                 fp = 8'd127 - 8'($urandom_range(100)); end
        default: ;
      endcase
      write_reg(CFG_SLICE_MODE, {7'($urandom), mode});
      write_reg(CFG_SIMPLE_THRESHOLD, thr);
      write_reg(CFG_RISE_POINT, rp);
      write_reg(CFG_FALL_POINT, fp);
      if (p == 6) write_reg(8'($urandom_range(255, 4)), 8'($urandom));
      quiet = (p == 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < 15) read_bucket(5'($urandom));
        else feed(pick_sample(), $urandom_range(9) == 0);
      end
      drain();
    end
    quiet = 1'b0;

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
